FILE: hw/rtl/perlin_noise_3d_assert.svh
// Assertion macros for the permutation-table noise block.
// Used by the top level only.
`ifndef PERLIN_NOISE_3D_ASSERT_SVH
`define PERLIN_NOISE_3D_ASSERT_SVH
`define PN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PN_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: hw/rtl/pn3_pkg.sv
// Package for the 3D noise block: widths, constants and a status type.
// No dependencies.
`default_nettype none
package pn3_pkg;
  localparam int unsigned PermEntries = 512;
  localparam int unsigned FracBits = 16;
  localparam int unsigned PermAw = 9;
  localparam int unsigned OutW = 18;
  localparam logic CmdEval = 1'b0;
  localparam logic CmdLoad = 1'b1;

  typedef struct packed {
    logic busy;
    logic out_valid;
  } pn3_status_t;
endpackage
`default_nettype wire

FILE: hw/rtl/pn3_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module pn3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/perlin_noise_3d.sv
// Improved 3D Perlin noise: one evaluate request in, one Q1.16 result out.
// Load requests write one permutation byte and give no result.
// Evaluate: 14 table reads on one RAM port, then 3 fades and 7 lerps on one shared multiplier.
// A new evaluate request is taken only when idle; an untaken result holds the next at its last lerp.
// Reset clears control state; the permutation table is undefined until loaded.
`default_nettype none
`include "perlin_noise_3d_assert.svh"
module perlin_noise_3d #(
  parameter int unsigned PERM_ENTRIES = pn3_pkg::PermEntries,
  parameter int unsigned FRAC_BITS = pn3_pkg::FracBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic        cmd_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  input  wire logic [8:0]  table_index_i,
  input  wire logic [7:0]  table_value_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic signed [17:0] noise_value_o
);
  import pn3_pkg::*;
  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned AW = $clog2(PERM_ENTRIES);
  localparam int unsigned VW = F + 4;
  localparam int unsigned MW = 2 * VW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH_REQ, S_HASH_WAIT, S_FADE, S_FADE_WAIT, S_FADE_COMB,
    S_LERP, S_LERP_WAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [AW-1:0] raddr;
  logic [7:0] rdata;
  logic [AW-1:0] waddr;
  logic we;

  logic [7:0] xi_q, yi_q, zi_q;
  logic [F-1:0] xf_q, yf_q, zf_q;
  logic [3:0] step_q;
  logic [8:0] a_q, b_q, aa_q, ab_q, ba_q, bb_q;
  logic [3:0] h_q [8];
  logic signed [VW-1:0] fd_q [3];
  logic signed [VW-1:0] t_q [5];
  logic signed [VW-1:0] g_q [8];
  logic signed [VW-1:0] ev_q [7];
  logic [1:0] fi_q;
  logic [2:0] fk_q;
  logic [2:0] li_q;
  logic signed [VW-1:0] ma_q, mb_q;
  logic signed [MW-1:0] prod_q;
  logic signed [17:0] res_q;
  logic out_v_q;
  logic out_v_d;
  logic out_fire;
  pn3_status_t st;

  assign we = valid_i && ready_o && (cmd_i == CmdLoad);
  assign waddr = table_index_i[AW-1:0];

  pn3_ram #(.Width(8), .Depth(PERM_ENTRIES)) u_perm (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(table_value_i),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic signed [VW-1:0] grad_f(
    input logic [3:0] h, input logic signed [VW-1:0] x,
    input logic signed [VW-1:0] y, input logic signed [VW-1:0] z);
    logic signed [VW-1:0] u, v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    grad_f = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic [8:0] addr_lut;
  always_comb begin
    case (step_q)
      4'd0: addr_lut = {1'b0, xi_q};
      4'd1: addr_lut = {1'b0, xi_q} + 9'd1;
      4'd2: addr_lut = a_q;
      4'd3: addr_lut = a_q + 9'd1;
      4'd4: addr_lut = b_q;
      4'd5: addr_lut = b_q + 9'd1;
      4'd6: addr_lut = aa_q;
      4'd7: addr_lut = ba_q;
      4'd8: addr_lut = ab_q;
      4'd9: addr_lut = bb_q;
      4'd10: addr_lut = aa_q + 9'd1;
      4'd11: addr_lut = ba_q + 9'd1;
      4'd12: addr_lut = ab_q + 9'd1;
      4'd13: addr_lut = bb_q + 9'd1;
      default: addr_lut = '0;
    endcase
  end
  assign raddr = addr_lut[AW-1:0];

  logic signed [VW-1:0] one_v, xf0, yf0, zf0, xf1, yf1, zf1;
  assign one_v = VW'(1) <<< F;
  assign xf0 = VW'({4'b0, xf_q});
  assign yf0 = VW'({4'b0, yf_q});
  assign zf0 = VW'({4'b0, zf_q});
  assign xf1 = xf0 - one_v;
  assign yf1 = yf0 - one_v;
  assign zf1 = zf0 - one_v;

  logic signed [VW-1:0] fsel;
  always_comb begin
    case (fi_q)
      2'd0: fsel = xf0;
      2'd1: fsel = yf0;
      default: fsel = zf0;
    endcase
  end

  logic signed [VW+5:0] fcomb;
  assign fcomb = (VW+6)'(10) * (VW+6)'(t_q[2]) - (VW+6)'(15) * (VW+6)'(t_q[3])
               + (VW+6)'(6) * (VW+6)'(t_q[4]);

  logic signed [VW-1:0] lt, la, lb;
  always_comb begin
    case (li_q)
      3'd0: begin lt = fd_q[0]; la = g_q[0]; lb = g_q[1]; end
      3'd1: begin lt = fd_q[0]; la = g_q[2]; lb = g_q[3]; end
      3'd2: begin lt = fd_q[0]; la = g_q[4]; lb = g_q[5]; end
      3'd3: begin lt = fd_q[0]; la = g_q[6]; lb = g_q[7]; end
      3'd4: begin lt = fd_q[1]; la = ev_q[0]; lb = ev_q[1]; end
      3'd5: begin lt = fd_q[1]; la = ev_q[2]; lb = ev_q[3]; end
      default: begin lt = fd_q[2]; la = ev_q[4]; lb = ev_q[5]; end
    endcase
  end

  logic signed [VW-1:0] lres;
  assign lres = la + VW'(prod_q >>> F);

  logic signed [VW-1:0] sres;
  logic signed [VW+16:0] wide;
  always_comb begin
    if (F >= 16) wide = (VW+17)'(lres >>> (F - 16));
    else wide = (VW+17)'(lres) <<< (16 - F);
    sres = '0;
  end
  logic signed [17:0] sat;
  always_comb begin
    if (wide < -(VW+17)'(131072)) sat = -18'sd131072;
    else if (wide > (VW+17)'(131071)) sat = 18'sd131071;
    else sat = wide[17:0];
  end

  assign out_fire = (state_q == S_OUT) && (li_q == 3'd6) && (!out_v_q || ready_i);
  assign out_v_d = out_fire || (out_v_q && !ready_i);

  assign st.busy = (state_q != S_IDLE);
  assign st.out_valid = out_v_q;
  assign ready_o = !st.busy;
  assign valid_o = out_v_q;
  assign noise_value_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      step_q <= '0;
      fi_q <= '0;
      fk_q <= '0;
      li_q <= '0;
    end else begin
      out_v_q <= out_v_d;
      case (state_q)
        S_IDLE: begin
          if (valid_i && ready_o && cmd_i == CmdEval) begin
            xi_q <= coord_x_i[F+7:F];
            yi_q <= coord_y_i[F+7:F];
            zi_q <= coord_z_i[F+7:F];
            xf_q <= coord_x_i[F-1:0];
            yf_q <= coord_y_i[F-1:0];
            zf_q <= coord_z_i[F-1:0];
            step_q <= '0;
            state_q <= S_HASH_REQ;
          end
        end
        S_HASH_REQ: state_q <= S_HASH_WAIT;
        S_HASH_WAIT: begin
          case (step_q)
            4'd0: a_q <= {1'b0, rdata} + {1'b0, yi_q};
            4'd1: b_q <= {1'b0, rdata} + {1'b0, yi_q};
            4'd2: aa_q <= {1'b0, rdata} + {1'b0, zi_q};
            4'd3: ab_q <= {1'b0, rdata} + {1'b0, zi_q};
            4'd4: ba_q <= {1'b0, rdata} + {1'b0, zi_q};
            4'd5: bb_q <= {1'b0, rdata} + {1'b0, zi_q};
            default: h_q[3'(step_q - 4'd6)] <= rdata[3:0];
          endcase
          if (step_q == 4'd13) begin
            fi_q <= '0;
            fk_q <= '0;
            state_q <= S_FADE;
          end else begin
            step_q <= step_q + 4'd1;
            state_q <= S_HASH_REQ;
          end
        end
        S_FADE: begin
          g_q[0] <= grad_f(h_q[0], xf0, yf0, zf0);
          g_q[1] <= grad_f(h_q[1], xf1, yf0, zf0);
          g_q[2] <= grad_f(h_q[2], xf0, yf1, zf0);
          g_q[3] <= grad_f(h_q[3], xf1, yf1, zf0);
          g_q[4] <= grad_f(h_q[4], xf0, yf0, zf1);
          g_q[5] <= grad_f(h_q[5], xf1, yf0, zf1);
          g_q[6] <= grad_f(h_q[6], xf0, yf1, zf1);
          g_q[7] <= grad_f(h_q[7], xf1, yf1, zf1);
          ma_q <= (fk_q == 3'd0) ? fsel : t_q[fk_q];
          mb_q <= fsel;
          state_q <= S_FADE_WAIT;
        end
        S_FADE_WAIT: begin
          prod_q <= MW'(ma_q) * MW'(mb_q);
          state_q <= S_FADE_COMB;
        end
        S_FADE_COMB: begin
          if (fk_q == 3'd4) begin
            if (fcomb < 0) fd_q[fi_q] <= '0;
            else if (fcomb > (VW+6)'(one_v)) fd_q[fi_q] <= one_v;
            else fd_q[fi_q] <= VW'(fcomb);
            fk_q <= '0;
            if (fi_q == 2'd2) begin
              li_q <= '0;
              state_q <= S_LERP;
            end else begin
              fi_q <= fi_q + 2'd1;
              state_q <= S_FADE;
            end
          end else begin
            t_q[fk_q + 3'd1] <= VW'(prod_q >>> F);
            fk_q <= fk_q + 3'd1;
            state_q <= (fk_q == 3'd3) ? S_FADE_COMB : S_FADE;
          end
        end
        S_LERP: begin
          ma_q <= lt;
          mb_q <= lb - la;
          state_q <= S_LERP_WAIT;
        end
        S_LERP_WAIT: begin
          prod_q <= MW'(ma_q) * MW'(mb_q);
          state_q <= S_OUT;
        end
        S_OUT: begin
          ev_q[li_q] <= lres;
          if (li_q == 3'd6) begin
            if (out_fire) begin
              res_q <= sat;
              state_q <= S_IDLE;
            end
          end else begin
            li_q <= li_q + 3'd1;
            state_q <= S_LERP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^sres;

  `PN_ASSERT(a_no_accept_busy, clk_i, rst_ni, (st.busy |-> !ready_o),
    "request accepted while busy")
  `PN_ASSERT(a_out_hold, clk_i, rst_ni, (valid_o && !ready_i |=> valid_o),
    "result dropped before taken")
  `PN_ASSERT_RST(a_rst_idle, clk_i, (!rst_ni |-> !valid_o), "result valid in reset")
endmodule
`default_nettype wire
